>>> hdl/iiba_pkg.sv
package iiba_pkg;

   localparam int WORD_W  = 64;
   localparam int POS_W   = 6;
   localparam int GRANT_W = 14;
   localparam int REQ_W   = 16;

   typedef enum logic [1:0] {
      MODE_FIRST_FREE = 2'd0,
      MODE_ALLOC      = 2'd1,
      MODE_FREE       = 2'd2,
      MODE_UNUSED     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_RANGE     = 3'd2,
      ST_IN_USE    = 3'd3,
      ST_NOT_ALLOC = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [REQ_W-1:0] requested_instance;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [GRANT_W-1:0] granted_instance;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic walk;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
      logic first_free;
   } sts_type;

   // index of the lowest clear bit of a map or summary word
   function automatic logic [POS_W-1:0] lowest_zero(input logic [WORD_W-1:0] word);
      logic [POS_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            idx = POS_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

>>> hdl/iiba_ram.sv
module iiba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/iiba_ctrl.sv
module iiba_ctrl import iiba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_SUM   = 4'b0100,
      S_MAP   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.first_free ? S_SUM : S_MAP;
            end
         end
         S_SUM: begin
            cmd.walk = 1'b1;
            state_in = S_MAP;
         end
         S_MAP: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/iiba_dp.sv
module iiba_dp import iiba_pkg::*; #(
   parameter int MAX_INSTANCES = 16384
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int MAP_WORDS = (MAX_INSTANCES + WORD_W - 1) / WORD_W;
   localparam int SUM_WORDS = (MAP_WORDS + WORD_W - 1) / WORD_W;
   localparam int MW_W      = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
   localparam int SW_W      = SUM_WORDS > 1 ? $clog2(SUM_WORDS) : 1;
   localparam int MAP_REM   = MAX_INSTANCES % WORD_W;
   localparam int SUM_REM   = MAP_WORDS % WORD_W;
   localparam logic [WORD_W-1:0] MAP_PAD =
      MAP_REM == 0 ? '0 : ~((64'd1 << MAP_REM) - 64'd1);
   localparam logic [WORD_W-1:0] SUM_PAD =
      SUM_REM == 0 ? '0 : ~((64'd1 << SUM_REM) - 64'd1);

   // clearing pass
   logic [MW_W-1:0] clr_ff, clr_in;

   // captured request
   logic [1:0]        mode_ff;
   logic [REQ_W-1:0]  req_ff;
   logic              range_ok_ff;
   logic              full_ff;
   logic [MW_W-1:0]   w1_ff, w1_in;
   logic [SW_W-1:0]   w2_ff, w2_in;
   logic [SUM_WORDS-1:0] top_ff, top_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // ram ports
   logic              map_we, map_re, sum_we, sum_re;
   logic [MW_W-1:0]   map_waddr, map_raddr;
   logic [SW_W-1:0]   sum_waddr, sum_raddr;
   logic [WORD_W-1:0] map_wdata, map_rd, sum_wdata, sum_rd;

   logic              req_in_range;
   logic              top_full;
   logic [SW_W-1:0]   top_lz;
   logic              is_first;

   // commit stage
   logic [POS_W-1:0]  pos;
   logic [POS_W-1:0]  sum_pos;
   logic              bit_now;
   logic              do_write;
   logic              do_set;
   logic [2:0]        status;
   logic [WORD_W-1:0] new_map, new_sum, bit_oh, sum_oh;

   assign is_first     = req_data.mode == MODE_FIRST_FREE;
   assign req_in_range = {1'b0, req_data.requested_instance} < 17'(MAX_INSTANCES);
   assign top_full     = &top_ff;

   always_comb begin
      top_lz = '0;
      for (int i = SUM_WORDS - 1; i >= 0; i--) begin
         if (!top_ff[i]) begin
            top_lz = SW_W'(i);
         end
      end
   end

   // read side
   always_comb begin
      sum_re    = 1'b0;
      map_re    = 1'b0;
      sum_raddr = SW_W'(req_data.requested_instance >> 12);
      map_raddr = MW_W'(req_data.requested_instance >> 6);
      w1_in     = w1_ff;
      w2_in     = w2_ff;
      if (cmd.accept) begin
         if (is_first) begin
            sum_re    = !top_full;
            sum_raddr = top_lz;
            w2_in     = top_lz;
         end else begin
            sum_re = req_in_range;
            map_re = req_in_range;
            w1_in  = MW_W'(req_data.requested_instance >> 6);
            w2_in  = SW_W'(req_data.requested_instance >> 12);
         end
      end else if (cmd.walk) begin
         map_re    = !full_ff;
         map_raddr = MW_W'((32'(w2_ff) << 6) | 32'(lowest_zero(sum_rd)));
         w1_in     = map_raddr;
      end
   end

   // result and write-back
   always_comb begin
      pos      = (mode_ff == MODE_FIRST_FREE) ? lowest_zero(map_rd) : req_ff[POS_W-1:0];
      bit_now  = map_rd[pos];
      do_write = 1'b0;
      do_set   = 1'b1;
      status   = ST_RANGE;
      unique case (mode_ff)
         MODE_FIRST_FREE: begin
            if (full_ff) begin
               status = ST_FULL;
            end else begin
               status   = ST_OK;
               do_write = 1'b1;
            end
         end
         MODE_ALLOC: begin
            if (!range_ok_ff) begin
               status = ST_RANGE;
            end else if (bit_now) begin
               status = ST_IN_USE;
            end else begin
               status   = ST_OK;
               do_write = 1'b1;
            end
         end
         MODE_FREE: begin
            do_set = 1'b0;
            if (!range_ok_ff) begin
               status = ST_RANGE;
            end else if (!bit_now) begin
               status = ST_NOT_ALLOC;
            end else begin
               status   = ST_OK;
               do_write = 1'b1;
            end
         end
         default: begin
            status = ST_RANGE;
         end
      endcase

      bit_oh  = 64'd1 << pos;
      sum_pos = POS_W'(w1_ff);
      sum_oh  = 64'd1 << sum_pos;
      if (do_set) begin
         new_map = map_rd | bit_oh;
         new_sum = (&new_map) ? (sum_rd | sum_oh) : sum_rd;
      end else begin
         new_map = map_rd & ~bit_oh;
         new_sum = sum_rd & ~sum_oh;
      end

      rsp_in.status           = status;
      rsp_in.granted_instance = (status == ST_OK) ? GRANT_W'({w1_ff, pos}) : '0;
   end

   always_comb begin
      map_we    = 1'b0;
      sum_we    = 1'b0;
      map_waddr = w1_ff;
      sum_waddr = w2_ff;
      map_wdata = new_map;
      sum_wdata = new_sum;
      top_in    = top_ff;
      clr_in    = clr_ff;
      if (cmd.clear) begin
         map_we    = 1'b1;
         map_waddr = clr_ff;
         map_wdata = (clr_ff == MW_W'(MAP_WORDS - 1)) ? MAP_PAD : '0;
         sum_we    = 32'(clr_ff) < SUM_WORDS;
         sum_waddr = SW_W'(clr_ff);
         sum_wdata = (32'(clr_ff) == SUM_WORDS - 1) ? SUM_PAD : '0;
         clr_in    = clr_ff + MW_W'(1);
      end else if (cmd.commit && do_write) begin
         map_we = 1'b1;
         sum_we = 1'b1;
         if (do_set) begin
            if (&new_sum) begin
               top_in[w2_ff] = 1'b1;
            end
         end else begin
            top_in[w2_ff] = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff     <= req_data.mode;
         req_ff      <= req_data.requested_instance;
         range_ok_ff <= req_in_range;
         full_ff     <= is_first && top_full;
      end
      w1_ff <= w1_in;
      w2_ff <= w2_in;
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   iiba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAP_WORDS)
   ) u_map_ram (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .re    (map_re),
      .raddr (map_raddr),
      .rdata (map_rd)
   );

   iiba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SUM_WORDS)
   ) u_sum_ram (
      .clock (clock),
      .we    (sum_we),
      .waddr (sum_waddr),
      .wdata (sum_wdata),
      .re    (sum_re),
      .raddr (sum_raddr),
      .rdata (sum_rd)
   );

   assign sts.clear_last = clr_ff == MW_W'(MAP_WORDS - 1);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign sts.first_free = is_first;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;

endmodule

>>> hdl/instance_id_bitmap_allocator.sv
// channel   ports                          item
// request   req_valid req_ready req_data   mode, requested_instance
// result    rsp_valid rsp_ready rsp_data   status, granted_instance
//
// lowest-free steps through the top summary, a summary word read and a map word read
// allocate and free of a given number take one map and summary read
// after reset a clearing pass over all ceil(MAX_INSTANCES / 64) map words runs
// before the first item is taken
// a result waits in an output register; a stalled result holds the next item
// in its last cycle until the register frees
module instance_id_bitmap_allocator import iiba_pkg::*; #(
   parameter int MAX_INSTANCES = 16384
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   iiba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   iiba_dp #(
      .MAX_INSTANCES (MAX_INSTANCES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
